[rtl/ascii_command_frame_decoder_top_macros.svh]
// assertion macros for the ascii command frame decoder checker
// expects clk and rst in the scope of use
`ifndef ASCII_COMMAND_FRAME_DECODER_TOP_MACROS_SVH
`define ASCII_COMMAND_FRAME_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define ACFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ACFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/acfd_pkg.sv]
// shared constants for the ascii command frame decoder
// command codes, action codes and frame geometry; no dependencies
package acfd_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int DIGIT_LIMIT = 9;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int DCNT_W      = $clog2(DIGIT_LIMIT + 1);
  localparam int NUM_W       = 30;

  localparam logic [7:0] CHAR_OPEN  = 8'h28;
  localparam logic [7:0] CHAR_CLOSE = 8'h29;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [NUM_W-1:0] CMD_STOP_TOGGLE = 30'd101;
  localparam logic [NUM_W-1:0] CMD_SHOW_SAVED  = 30'd102;
  localparam logic [NUM_W-1:0] CMD_COUPLE_AC   = 30'd104;
  localparam logic [NUM_W-1:0] CMD_COUPLE_DC   = 30'd105;
  localparam logic [NUM_W-1:0] CMD_GAIN_SET    = 30'd111;
  localparam logic [NUM_W-1:0] CMD_GAIN_UP     = 30'd112;
  localparam logic [NUM_W-1:0] CMD_GAIN_DOWN   = 30'd113;
  localparam logic [NUM_W-1:0] CMD_TB_SET      = 30'd121;
  localparam logic [NUM_W-1:0] CMD_TB_UP       = 30'd122;
  localparam logic [NUM_W-1:0] CMD_TB_DOWN     = 30'd123;
  localparam logic [NUM_W-1:0] CMD_GEN_FIRST   = 30'd131;
  localparam logic [NUM_W-1:0] CMD_GEN_LAST    = 30'd134;
  localparam logic [NUM_W-1:0] DATA_FREQ       = 30'd1301;
  localparam logic [NUM_W-1:0] DATA_VPP        = 30'd1302;
  localparam logic [NUM_W-1:0] DATA_DUTY       = 30'd1303;

  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_SHOW_SAVED = 3'd1;
  localparam logic [2:0] ACT_GAIN       = 3'd2;
  localparam logic [2:0] ACT_TIMEBASE   = 3'd3;
  localparam logic [2:0] ACT_GEN_START  = 3'd4;

  localparam logic [3:0] GAIN_MIN  = 4'd1;
  localparam logic [3:0] GAIN_MAX  = 4'd8;
  localparam logic [3:0] GAIN_INIT = 4'd3;

  localparam logic [9:0] TB_MIN  = 10'd1;
  localparam logic [9:0] TB_MAX  = 10'd1000;
  localparam logic [9:0] TB_INIT = 10'd99;
  localparam logic [9:0] TB_STEP = 10'd5;

endpackage

[rtl/ascii_command_frame_decoder_top.sv]
// ascii command frame decoder: a frame's closing byte passes the input byte
// register, then its result is written to the output registers
// throughput one byte per cycle while byte_stall is low; one result per frame
// of FRAME_BYTES bytes; the byte register feeds the parser and command logic
// synchronous active-high reset clears the parser, the settings (gain 3,
// timebase 99) and both valid flags
module ascii_command_frame_decoder_top
  import acfd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             byte_valid,
  output logic             byte_stall,
  input  logic [7:0]       byte_in,
  output logic             result_valid,
  input  logic             result_stall,
  output logic             frame_ok,
  output logic [NUM_W-1:0] code,
  output logic [NUM_W-1:0] argument,
  output logic             stopped,
  output logic             ac_coupling,
  output logic [3:0]       gain_level,
  output logic [9:0]       time_base,
  output logic [NUM_W-1:0] gen_frequency,
  output logic [NUM_W-1:0] gen_vpp_tenths,
  output logic [NUM_W-1:0] gen_duty,
  output logic [2:0]       action,
  output logic [1:0]       wave_kind
);

  typedef enum logic [1:0] {
    PH_CODE,
    PH_SKIP,
    PH_VALUE,
    PH_DONE
  } phase_t;

  localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0]  POS_FIRST = POS_W'(2);
  localparam logic [DCNT_W-1:0] DCNT_MAX  = DCNT_W'(DIGIT_LIMIT);

  // input byte register
  logic       q_valid;
  logic [7:0] q_byte;

  // parser state
  logic [POS_W-1:0]  byte_position, byte_position_next;
  phase_t            parse_phase, parse_phase_next;
  logic              header_seen, header_seen_next;
  logic [NUM_W-1:0]  code_accum, code_accum_next;
  logic [NUM_W-1:0]  value_accum, value_accum_next;
  logic [DCNT_W-1:0] digit_count, digit_count_next;

  // settings
  logic             stop_flag, stop_flag_next;
  logic             coupling_flag, coupling_flag_next;
  logic [3:0]       gain_reg, gain_reg_next;
  logic [9:0]       timebase_reg, timebase_reg_next;
  logic [NUM_W-1:0] freq_reg, freq_reg_next;
  logic [NUM_W-1:0] vpp_reg, vpp_reg_next;
  logic [NUM_W-1:0] duty_reg, duty_reg_next;

  logic             process;
  logic             last_byte;
  logic             is_digit;
  logic [NUM_W-1:0] digit_val;
  logic [NUM_W-1:0] accum_sel;
  logic [NUM_W-1:0] accum_x10;
  logic [DCNT_W-1:0] dcnt_inc;
  logic             ok;
  logic [2:0]       action_next;
  logic [1:0]       wave_next;
  logic [10:0]      tb_plus;

  assign last_byte  = (byte_position == POS_LAST);
  assign process    = q_valid && (!last_byte || !result_valid || !result_stall);
  assign byte_stall = q_valid && !process;

  assign is_digit  = (q_byte >= CHAR_ZERO) && (q_byte <= CHAR_NINE);
  assign digit_val = NUM_W'(q_byte[3:0]);
  assign accum_sel = (parse_phase == PH_CODE) ? code_accum : value_accum;
  assign accum_x10 = (accum_sel << 3) + (accum_sel << 1) + digit_val;
  assign dcnt_inc  = digit_count + DCNT_W'(1);
  assign ok        = header_seen && (q_byte == CHAR_CLOSE);
  assign tb_plus   = {1'b0, timebase_reg} + {1'b0, TB_STEP};

  always_comb begin
    byte_position_next = byte_position;
    parse_phase_next   = parse_phase;
    header_seen_next   = header_seen;
    code_accum_next    = code_accum;
    value_accum_next   = value_accum;
    digit_count_next   = digit_count;
    stop_flag_next     = stop_flag;
    coupling_flag_next = coupling_flag;
    gain_reg_next      = gain_reg;
    timebase_reg_next  = timebase_reg;
    freq_reg_next      = freq_reg;
    vpp_reg_next       = vpp_reg;
    duty_reg_next      = duty_reg;
    action_next        = ACT_NONE;
    wave_next          = 2'd0;

    if (byte_position == '0) begin
      parse_phase_next   = PH_CODE;
      code_accum_next    = '0;
      value_accum_next   = '0;
      digit_count_next   = '0;
      header_seen_next   = (q_byte == CHAR_OPEN);
      byte_position_next = POS_W'(1);
    end else if (!last_byte) begin
      byte_position_next = byte_position + POS_W'(1);
      if (byte_position >= POS_FIRST) begin
        unique case (parse_phase)
          PH_CODE: begin
            if (is_digit) begin
              code_accum_next = accum_x10;
              if (dcnt_inc >= DCNT_MAX) begin
                digit_count_next = '0;
                parse_phase_next = PH_SKIP;
              end else begin
                digit_count_next = dcnt_inc;
              end
            end else begin
              digit_count_next = '0;
              parse_phase_next = PH_VALUE;
            end
          end
          PH_SKIP: parse_phase_next = PH_VALUE;
          PH_VALUE: begin
            if (is_digit) begin
              value_accum_next = accum_x10;
              digit_count_next = dcnt_inc;
              if (dcnt_inc >= DCNT_MAX) begin
                parse_phase_next = PH_DONE;
              end
            end else begin
              parse_phase_next = PH_DONE;
            end
          end
          PH_DONE: parse_phase_next = PH_DONE;
          default: parse_phase_next = PH_DONE;
        endcase
      end
    end else begin
      byte_position_next = '0;
      parse_phase_next   = PH_CODE;
      header_seen_next   = 1'b0;
      code_accum_next    = '0;
      value_accum_next   = '0;
      digit_count_next   = '0;
      if (ok) begin
        unique case (code_accum) inside
          CMD_STOP_TOGGLE: stop_flag_next = !stop_flag;
          CMD_SHOW_SAVED:  action_next = ACT_SHOW_SAVED;
          CMD_COUPLE_AC:   coupling_flag_next = 1'b1;
          CMD_COUPLE_DC:   coupling_flag_next = 1'b0;
          CMD_GAIN_SET: begin
            if (value_accum >= NUM_W'(GAIN_MIN) && value_accum <= NUM_W'(GAIN_MAX)) begin
              gain_reg_next = value_accum[3:0];
            end
            action_next = ACT_GAIN;
          end
          CMD_GAIN_UP: begin
            gain_reg_next = (gain_reg >= GAIN_MAX) ? GAIN_MIN : gain_reg + 4'd1;
            action_next   = ACT_GAIN;
          end
          CMD_GAIN_DOWN: begin
            gain_reg_next = (gain_reg <= GAIN_MIN) ? GAIN_MAX : gain_reg - 4'd1;
            action_next   = ACT_GAIN;
          end
          CMD_TB_SET: begin
            if (value_accum <= NUM_W'(TB_MAX)) begin
              timebase_reg_next = value_accum[9:0];
            end
            action_next = ACT_TIMEBASE;
          end
          CMD_TB_UP: begin
            timebase_reg_next = (tb_plus >= {1'b0, TB_MAX}) ? TB_MAX : tb_plus[9:0];
            action_next       = ACT_TIMEBASE;
          end
          CMD_TB_DOWN: begin
            timebase_reg_next = (timebase_reg <= TB_STEP + TB_MIN) ? TB_MIN
                                                                   : timebase_reg - TB_STEP;
            action_next       = ACT_TIMEBASE;
          end
          [CMD_GEN_FIRST:CMD_GEN_LAST]: begin
            action_next = ACT_GEN_START;
            wave_next   = 2'(code_accum - CMD_GEN_FIRST);
          end
          DATA_FREQ: freq_reg_next = value_accum;
          DATA_VPP:  vpp_reg_next  = value_accum;
          DATA_DUTY: duty_reg_next = value_accum;
          default:   action_next   = ACT_NONE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid       <= 1'b0;
      result_valid  <= 1'b0;
      byte_position <= '0;
      parse_phase   <= PH_CODE;
      header_seen   <= 1'b0;
      code_accum    <= '0;
      value_accum   <= '0;
      digit_count   <= '0;
      stop_flag     <= 1'b0;
      coupling_flag <= 1'b0;
      gain_reg      <= GAIN_INIT;
      timebase_reg  <= TB_INIT;
      freq_reg      <= '0;
      vpp_reg       <= '0;
      duty_reg      <= '0;
    end else begin
      if (!byte_stall) begin
        q_valid <= byte_valid;
      end
      if (process) begin
        byte_position <= byte_position_next;
        parse_phase   <= parse_phase_next;
        header_seen   <= header_seen_next;
        code_accum    <= code_accum_next;
        value_accum   <= value_accum_next;
        digit_count   <= digit_count_next;
        stop_flag     <= stop_flag_next;
        coupling_flag <= coupling_flag_next;
        gain_reg      <= gain_reg_next;
        timebase_reg  <= timebase_reg_next;
        freq_reg      <= freq_reg_next;
        vpp_reg       <= vpp_reg_next;
        duty_reg      <= duty_reg_next;
      end
      if (process && last_byte) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      q_byte <= byte_in;
    end
    if (process && last_byte) begin
      frame_ok       <= ok;
      code           <= ok ? code_accum : '0;
      argument       <= ok ? value_accum : '0;
      stopped        <= stop_flag_next;
      ac_coupling    <= coupling_flag_next;
      gain_level     <= gain_reg_next;
      time_base      <= timebase_reg_next;
      gen_frequency  <= freq_reg_next;
      gen_vpp_tenths <= vpp_reg_next;
      gen_duty       <= duty_reg_next;
      action         <= action_next;
      wave_kind      <= wave_next;
    end
  end

endmodule

[rtl/acfd_checker.sv]
// port-level checker for the ascii command frame decoder, bound to the top
// depends on acfd_pkg and ascii_command_frame_decoder_top_macros.svh
`include "ascii_command_frame_decoder_top_macros.svh"

module acfd_checker
  import acfd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             byte_valid,
  input logic             byte_stall,
  input logic [7:0]       byte_in,
  input logic             result_valid,
  input logic             result_stall,
  input logic             frame_ok,
  input logic [NUM_W-1:0] code,
  input logic [NUM_W-1:0] argument,
  input logic [3:0]       gain_level,
  input logic [9:0]       time_base,
  input logic [2:0]       action,
  input logic [1:0]       wave_kind
);

  `ACFD_ASSERT_NEXT(a_byte_hold, byte_valid && byte_stall, byte_valid && $stable(byte_in), "stalled byte transfer changed")

  `ACFD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(code) && $stable(argument) && $stable(action), "stalled result transfer changed")

  `ACFD_ASSERT_NOW(a_bad_frame_quiet, result_valid && !frame_ok, code == '0 && argument == '0 && action == ACT_NONE, "rejected frame carries a command")

  `ACFD_ASSERT_NOW(a_settings_range, result_valid, gain_level >= GAIN_MIN && gain_level <= GAIN_MAX && time_base <= TB_MAX, "gain or timebase out of range")

  `ACFD_ASSERT_NOW(a_wave_only_on_gen, result_valid && action != ACT_GEN_START, wave_kind == 2'd0, "waveform set without generator start")

endmodule

bind ascii_command_frame_decoder_top acfd_checker u_acfd_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for ascii_command_frame_decoder_top, uses acfd_pkg
// drives 16-byte ascii frames, predicts each frame report and its settings in sv,
// and compares every report field with random idling on both channels
module tb;
  import acfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_BYTES   = 1072;

  typedef enum logic [1:0] {FLD_CODE, FLD_SKIP, FLD_VALUE, FLD_DONE} field_sel_t;

  typedef struct packed {
    logic             ok;
    logic [NUM_W-1:0] code;
    logic [NUM_W-1:0] arg;
    logic             stop;
    logic             ac;
    logic [3:0]       gain;
    logic [9:0]       tbase;
    logic [NUM_W-1:0] freq;
    logic [NUM_W-1:0] vpp;
    logic [NUM_W-1:0] duty;
    logic [2:0]       act;
    logic [1:0]       wave;
  } frame_report_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             byte_valid = 1'b0;
  logic             byte_stall;
  logic [7:0]       byte_in = 8'h00;
  logic             result_valid;
  logic             result_stall = 1'b0;
  logic             frame_ok;
  logic [NUM_W-1:0] code;
  logic [NUM_W-1:0] argument;
  logic             stopped;
  logic             ac_coupling;
  logic [3:0]       gain_level;
  logic [9:0]       time_base;
  logic [NUM_W-1:0] gen_frequency;
  logic [NUM_W-1:0] gen_vpp_tenths;
  logic [NUM_W-1:0] gen_duty;
  logic [2:0]       action;
  logic [1:0]       wave_kind;

  ascii_command_frame_decoder_top u_top (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .byte_in       (byte_in),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .frame_ok      (frame_ok),
    .code          (code),
    .argument      (argument),
    .stopped       (stopped),
    .ac_coupling   (ac_coupling),
    .gain_level    (gain_level),
    .time_base     (time_base),
    .gen_frequency (gen_frequency),
    .gen_vpp_tenths(gen_vpp_tenths),
    .gen_duty      (gen_duty),
    .action        (action),
    .wave_kind     (wave_kind)
  );

  always #5 clk = ~clk;

  // decoder state as predicted
  int               frame_pos;
  field_sel_t       field_sel;
  logic             hdr_seen;
  logic [NUM_W-1:0] code_acc;
  logic [NUM_W-1:0] val_acc;
  int               digits;
  logic             stop_q;
  logic             ac_q;
  logic [3:0]       gain_q;
  logic [9:0]       tbase_q;
  logic [NUM_W-1:0] freq_q;
  logic [NUM_W-1:0] vpp_q;
  logic [NUM_W-1:0] duty_q;

  frame_report_t    due_reports[$];
  frame_report_t    want;
  logic [7:0]       frame_buf [FRAME_BYTES];

  int mismatches     = 0;
  int bytes_sent     = 0;
  int frames_checked = 0;
  int ok_frames      = 0;
  int idle_cycles    = 0;
  int burst_left     = 0;
  bit idle_enable    = 1'b1;
  int stall_mode     = 0;
  int stall_left     = 0;

  function automatic void clear_parser();
    frame_pos = 0;
    field_sel = FLD_CODE;
    hdr_seen  = 1'b0;
    code_acc  = '0;
    val_acc   = '0;
    digits    = 0;
  endfunction

  // advances the predicted decoder by one byte, queues a report on the last byte
  function automatic void decode_byte(input logic [7:0] b);
    logic          dig;
    frame_report_t r;
    dig = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    bytes_sent++;
    if (frame_pos == 0) begin
      clear_parser();
      hdr_seen  = (b == CHAR_OPEN);
      frame_pos = 1;
    end else if (frame_pos + 1 < FRAME_BYTES) begin
      if (frame_pos >= 2) begin
        case (field_sel)
          FLD_CODE: begin
            if (dig) begin
              code_acc = NUM_W'(code_acc * 10 + b[3:0]);
              digits++;
              if (digits >= DIGIT_LIMIT) begin
                digits    = 0;
                field_sel = FLD_SKIP;
              end
            end else begin
              digits    = 0;
              field_sel = FLD_VALUE;
            end
          end
          FLD_SKIP: field_sel = FLD_VALUE;
          FLD_VALUE: begin
            if (dig) begin
              val_acc = NUM_W'(val_acc * 10 + b[3:0]);
              digits++;
              if (digits >= DIGIT_LIMIT) field_sel = FLD_DONE;
            end else begin
              field_sel = FLD_DONE;
            end
          end
          default: ;
        endcase
      end
      frame_pos++;
    end else begin
      r      = '0;
      r.ok   = hdr_seen && (b == CHAR_CLOSE);
      r.act  = ACT_NONE;
      if (r.ok) begin
        ok_frames++;
        r.code = code_acc;
        r.arg  = val_acc;
        case (code_acc)
          CMD_STOP_TOGGLE: stop_q = ~stop_q;
          CMD_SHOW_SAVED:  r.act = ACT_SHOW_SAVED;
          CMD_COUPLE_AC:   ac_q = 1'b1;
          CMD_COUPLE_DC:   ac_q = 1'b0;
          CMD_GAIN_SET: begin
            if (val_acc >= GAIN_MIN && val_acc <= GAIN_MAX) gain_q = val_acc[3:0];
            r.act = ACT_GAIN;
          end
          CMD_GAIN_UP: begin
            gain_q = (gain_q >= GAIN_MAX) ? GAIN_MIN : gain_q + 4'd1;
            r.act  = ACT_GAIN;
          end
          CMD_GAIN_DOWN: begin
            gain_q = (gain_q <= GAIN_MIN) ? GAIN_MAX : gain_q - 4'd1;
            r.act  = ACT_GAIN;
          end
          CMD_TB_SET: begin
            if (val_acc <= TB_MAX) tbase_q = val_acc[9:0];
            r.act = ACT_TIMEBASE;
          end
          CMD_TB_UP: begin
            tbase_q = (11'(tbase_q) + 11'(TB_STEP) >= 11'(TB_MAX)) ? TB_MAX
                                                                  : tbase_q + TB_STEP;
            r.act   = ACT_TIMEBASE;
          end
          CMD_TB_DOWN: begin
            tbase_q = (tbase_q <= TB_STEP + TB_MIN) ? TB_MIN : tbase_q - TB_STEP;
            r.act   = ACT_TIMEBASE;
          end
          DATA_FREQ: freq_q = val_acc;
          DATA_VPP:  vpp_q  = val_acc;
          DATA_DUTY: duty_q = val_acc;
          default: begin
            if (code_acc >= CMD_GEN_FIRST && code_acc <= CMD_GEN_LAST) begin
              r.act  = ACT_GEN_START;
              r.wave = 2'(code_acc - CMD_GEN_FIRST);
            end
          end
        endcase
      end
      r.stop  = stop_q;
      r.ac    = ac_q;
      r.gain  = gain_q;
      r.tbase = tbase_q;
      r.freq  = freq_q;
      r.vpp   = vpp_q;
      r.duty  = duty_q;
      due_reports.push_back(r);
      clear_parser();
    end
  endfunction

  function automatic void note_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $time, what);
  endfunction

  function automatic void check_field(input string name, input logic [NUM_W-1:0] want_v,
                                      input logic [NUM_W-1:0] got_v);
    if (want_v !== got_v)
      note_mismatch($sformatf("report %0d %s expected %0d got %0d", frames_checked, name,
                              want_v, got_v));
  endfunction

  function automatic logic [7:0] rand_non_digit();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b >= CHAR_ZERO && b <= CHAR_NINE);
    return b;
  endfunction

  // report checker
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      frames_checked++;
      if (due_reports.size() == 0) begin
        note_mismatch("report with none due");
      end else begin
        want = due_reports.pop_front();
        check_field("frame_ok", NUM_W'(want.ok), NUM_W'(frame_ok));
        check_field("code", want.code, code);
        check_field("argument", want.arg, argument);
        check_field("stopped", NUM_W'(want.stop), NUM_W'(stopped));
        check_field("ac_coupling", NUM_W'(want.ac), NUM_W'(ac_coupling));
        check_field("gain_level", NUM_W'(want.gain), NUM_W'(gain_level));
        check_field("time_base", NUM_W'(want.tbase), NUM_W'(time_base));
        check_field("gen_frequency", want.freq, gen_frequency);
        check_field("gen_vpp_tenths", want.vpp, gen_vpp_tenths);
        check_field("gen_duty", want.duty, gen_duty);
        check_field("action", NUM_W'(want.act), NUM_W'(action));
        check_field("wave_kind", NUM_W'(want.wave), NUM_W'(wave_kind));
      end
    end
  end

  // receiver stall pattern: modes from no stall to heavy stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 7) == 0);
      2: result_stall <= 1'($urandom_range(0, 1));
      default: result_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (idle_enable && burst_left == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    byte_valid <= 1'b1;
    byte_in    <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    decode_byte(b);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_frame_buf();
    for (int i = 0; i < FRAME_BYTES; i++) send_byte(frame_buf[i]);
  endtask

  // body goes from byte 2, the rest up to the trailer is non-digit filler
  task automatic send_frame_text(input string body, input logic [7:0] head,
                                 input logic [7:0] tail);
    frame_buf[0] = head;
    frame_buf[1] = 8'($urandom_range(0, 255));
    for (int p = 2; p < FRAME_BYTES - 1; p++)
      frame_buf[p] = (p - 2 < body.len()) ? body[p-2] : rand_non_digit();
    frame_buf[FRAME_BYTES-1] = tail;
    send_frame_buf();
  endtask

  // negative value leaves the value field empty
  task automatic send_cmd(input logic [NUM_W-1:0] c, input int v);
    logic [7:0] sep;
    string      body;
    do sep = 8'($urandom_range(33, 126)); while (sep >= CHAR_ZERO && sep <= CHAR_NINE);
    if (v < 0) body = $sformatf("%0d%c", c, sep);
    else body = $sformatf("%0d%c%0d", c, sep, v);
    send_frame_text(body, CHAR_OPEN, CHAR_CLOSE);
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    while (due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [NUM_W-1:0] pick_code();
    case ($urandom_range(0, 19))
      0:  return CMD_STOP_TOGGLE;
      1:  return CMD_SHOW_SAVED;
      2:  return CMD_COUPLE_AC;
      3:  return CMD_COUPLE_DC;
      4, 5:   return CMD_GAIN_SET;
      6:  return CMD_GAIN_UP;
      7:  return CMD_GAIN_DOWN;
      8, 9:   return CMD_TB_SET;
      10, 11: return CMD_TB_UP;
      12, 13: return CMD_TB_DOWN;
      14: return CMD_GEN_FIRST + NUM_W'($urandom_range(0, 3));
      15: return DATA_FREQ;
      16: return DATA_VPP;
      17: return DATA_DUTY;
      default: return NUM_W'($urandom_range(0, 2000));
    endcase
  endfunction

  function automatic int pick_arg(input logic [NUM_W-1:0] c);
    if ($urandom_range(0, 15) == 0) return -1;
    if (c == CMD_GAIN_SET) return $urandom_range(0, 10);
    if (c == CMD_TB_SET) begin
      if ($urandom_range(0, 7) == 0) return $urandom_range(1001, 99999999);
      return $urandom_range(0, 1000);
    end
    if (c == DATA_FREQ || c == DATA_VPP || c == DATA_DUTY)
      return $urandom % (10 ** $urandom_range(0, 8));
    return $urandom_range(0, 999);
  endfunction

  task automatic test_command_set();
    send_cmd(CMD_STOP_TOGGLE, -1);
    send_cmd(CMD_STOP_TOGGLE, 0);
    send_cmd(CMD_SHOW_SAVED, 0);
    send_cmd(CMD_COUPLE_AC, 0);
    send_cmd(CMD_COUPLE_DC, 0);
    send_cmd(CMD_GAIN_SET, int'(GAIN_MAX));
    send_cmd(CMD_GAIN_UP, 0);
    send_cmd(CMD_GAIN_DOWN, 0);
    send_cmd(CMD_GAIN_SET, 0);
    send_cmd(CMD_GAIN_SET, 9);
    send_cmd(CMD_TB_SET, 998);
    send_cmd(CMD_TB_UP, 0);
    send_cmd(CMD_TB_UP, 0);
    send_cmd(CMD_TB_SET, 1001);
    send_cmd(CMD_TB_SET, 0);
    send_cmd(CMD_TB_DOWN, 0);
    send_cmd(CMD_TB_SET, 7);
    send_cmd(CMD_TB_DOWN, 0);
    for (logic [NUM_W-1:0] c = CMD_GEN_FIRST; c <= CMD_GEN_LAST; c++) send_cmd(c, 0);
    send_cmd(DATA_FREQ, 99999999);
    send_cmd(DATA_VPP, 33);
    send_cmd(DATA_DUTY, 0);
    send_cmd(30'd999, 5);
    wait_drained();
  endtask

  task automatic test_digit_caps();
    // ninth code digit ends the field, the next digit is skipped
    send_frame_text("123456789542", CHAR_OPEN, CHAR_CLOSE);
    send_frame_text("9999999999999", CHAR_OPEN, CHAR_CLOSE);
    // value capped at nine digits
    send_frame_text("1,12345678901", CHAR_OPEN, CHAR_CLOSE);
    // value runs up to the trailer
    send_frame_text("1301,87654321", CHAR_OPEN, CHAR_CLOSE);
    send_frame_text("", CHAR_OPEN, CHAR_CLOSE);
    send_frame_text(",5", CHAR_OPEN, CHAR_CLOSE);
    wait_drained();
  endtask

  task automatic test_broken_framing();
    send_frame_text("101,0", 8'h00, CHAR_CLOSE);
    send_frame_text("101,0", CHAR_OPEN, "7");
    send_frame_text("1302,5", CHAR_CLOSE, CHAR_OPEN);
    send_frame_text("112,0", 8'hFF, 8'hFF);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int               stop_at;
    int               frame_no;
    int               kind;
    logic [NUM_W-1:0] c;
    stop_at  = bytes_sent + RANDOM_BYTES;
    frame_no = 0;
    while (bytes_sent < stop_at) begin
      if (frame_no % 20 == 0) idle_enable = ($urandom_range(0, 3) != 0);
      if (frame_no == 50) wait_drained();
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        c = pick_code();
        send_cmd(c, pick_arg(c));
      end else if (kind < 85) begin
        c = pick_code();
        send_frame_text($sformatf("%0d,%0d", c, $urandom_range(0, 999)),
                        $urandom_range(0, 1) ? CHAR_OPEN : 8'($urandom_range(0, 255)),
                        $urandom_range(0, 1) ? CHAR_CLOSE : 8'($urandom_range(0, 255)));
      end else if (kind < 93) begin
        // long digit runs with scattered non-digits
        frame_buf[0] = CHAR_OPEN;
        frame_buf[1] = 8'($urandom_range(0, 255));
        for (int p = 2; p < FRAME_BYTES - 1; p++)
          frame_buf[p] = ($urandom_range(0, 6) != 0) ? CHAR_ZERO + 8'($urandom_range(0, 9))
                                                      : rand_non_digit();
        frame_buf[FRAME_BYTES-1] = CHAR_CLOSE;
        send_frame_buf();
      end else begin
        for (int p = 0; p < FRAME_BYTES; p++) frame_buf[p] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1)) begin
          frame_buf[0]             = CHAR_OPEN;
          frame_buf[FRAME_BYTES-1] = CHAR_CLOSE;
        end
        send_frame_buf();
      end
      frame_no++;
    end
    byte_valid <= 1'b0;
  endtask

  initial begin
    stop_q  = 1'b0;
    ac_q    = 1'b0;
    gain_q  = GAIN_INIT;
    tbase_q = TB_INIT;
    freq_q  = '0;
    vpp_q   = '0;
    duty_q  = '0;
    clear_parser();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_command_set();
    test_digit_caps();
    test_broken_framing();
    test_random_traffic();

    while (due_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d bytes, checked %0d frame reports, %0d with good framing",
             bytes_sent, frames_checked, ok_frames);
    $display("covered every command, gain and timebase limits, digit caps and bad framing");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/acfd_pkg.sv
rtl/ascii_command_frame_decoder_top.sv
rtl/acfd_checker.sv
tb/tb.sv
